// ===== rtl/woas_pkg.sv =====
// Shared types and constants for the windowed overlap-add synthesis unit.
`timescale 1ns / 1ps

package woas_pkg;

   // Input command codes.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_FLUSH  = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;

   // Configuration register indexes (byte address is 8 times the index).
   localparam logic REG_HOP   = 1'b0;
   localparam logic REG_FLOOR = 1'b1;

   localparam int HOP_W    = 10;
   localparam int NORM_W   = 40;
   localparam int SUM_W    = 56;
   localparam int COEF_W   = 16;
   localparam int IDX_W    = 9;
   localparam int CSR_W    = 64;
   localparam int CSR_A_W  = 4;
   localparam logic [COEF_W-1:0] ONE_Q15 = 16'd32768;
   localparam logic [HOP_W-1:0]  HOP_RESET   = 10'd128;
   localparam logic [NORM_W-1:0] FLOOR_RESET = 40'd11;

   // Work handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ACCUM = 2'd1,
      OP_DRAIN = 2'd2,
      OP_CLEAR = 2'd3
   } job_op_type;

   // flag means "emit this slot" for an accumulate and "last of stream" for a drain.
   typedef struct packed {
      job_op_type op;
      logic       flag;
   } job_ctl_type;

   typedef struct packed {
      logic init_busy;
   } be_status_type;

endpackage

// ===== rtl/woas_if.sv =====
// Word channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface woas_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic signed [SAMPLE_BITS-1:0] frame_sample;
   logic [8:0]                    coef_index;
   logic [15:0]                   coef_value;

   modport source (output valid, command, frame_sample, coef_index, coef_value,
                   input ready);
   modport sink (input valid, command, frame_sample, coef_index, coef_value,
                 output ready);
endinterface

interface woas_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          last_of_stream;
   logic                          saturated;

   modport source (output valid, out_sample, last_of_stream, saturated, input ready);
   modport sink (input valid, out_sample, last_of_stream, saturated, output ready);
endinterface

// ===== rtl/woas_front.sv =====
// Front end: accepts request words, tracks stream position and issues jobs.
`timescale 1ns / 1ps

module woas_front
   import woas_pkg::*;
#(
   parameter int FRAME_LENGTH = 512,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   woas_req_if.sink                      req,
   input  logic [HOP_W-1:0]              hop_length,
   input  be_status_type                 status,
   input  logic                          q_full,
   output logic                          push,
   output job_ctl_type                   job_ctl,
   output logic [$clog2(FRAME_LENGTH)-1:0] job_addr,
   output logic [$clog2(FRAME_LENGTH)-1:0] job_widx,
   output logic signed [SAMPLE_BITS-1:0] job_sample,
   output logic [COEF_W-1:0]             job_coef
);

   localparam int PW = $clog2(FRAME_LENGTH);
   localparam int TW = $clog2(FRAME_LENGTH + 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] base_ff, base_in;
   logic [TW-1:0] tail_ff, tail_in;
   logic          active_ff, active_in;
   logic          drain_ff, drain_in;

   logic          accept;
   logic [TW-1:0] hop;
   logic [TW-1:0] p, start, fend;
   logic [PW-1:0] st_base;
   logic [TW-1:0] st_tail;
   logic          go;

   function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [TW-1:0] b);
      logic [TW:0] s;
      s = (TW+1)'(a) + (TW+1)'(b);
      if (s >= (TW+1)'(FRAME_LENGTH)) s = s - (TW+1)'(FRAME_LENGTH);
      return PW'(s);
   endfunction

   assign req.ready = !q_full && !status.init_busy;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (hop_length == '0) hop = TW'(1);
      else if (32'(hop_length) > FRAME_LENGTH) hop = TW'(FRAME_LENGTH);
      else hop = TW'(hop_length);
   end

   always_comb begin
      pos_in     = pos_ff;
      base_in    = base_ff;
      tail_in    = tail_ff;
      active_in  = active_ff;
      drain_in   = drain_ff;
      push       = 1'b0;
      job_ctl    = '{op: OP_LOAD, flag: 1'b0};
      job_addr   = wrap_add(base_ff, TW'(pos_ff));
      job_widx   = pos_ff;
      job_sample = req.frame_sample;
      job_coef   = (req.coef_value > ONE_Q15) ? ONE_Q15 : req.coef_value;
      p          = TW'(pos_ff);
      start      = (p < hop) ? p : hop;
      fend       = TW'(FRAME_LENGTH) - hop;
      st_base    = base_ff;
      st_tail    = tail_ff;
      go         = 1'b0;
      if (p > fend) fend = p;
      if (accept) begin
         unique case (req.command)
            CMD_SAMPLE: begin
               if (!drain_ff) begin
                  push      = 1'b1;
                  job_ctl   = '{op: OP_ACCUM, flag: (p < hop)};
                  active_in = 1'b1;
                  if (32'(pos_ff) == FRAME_LENGTH - 1) begin
                     pos_in  = '0;
                     base_in = wrap_add(base_ff, hop);
                  end else begin
                     pos_in = pos_ff + PW'(1);
                  end
               end
            end
            CMD_FLUSH: begin
               if (drain_ff) begin
                  go = 1'b1;
               end else if (active_ff) begin
                  if (fend <= start) begin
                     push      = 1'b1;
                     job_ctl   = '{op: OP_CLEAR, flag: 1'b0};
                     pos_in    = '0;
                     base_in   = '0;
                     tail_in   = '0;
                     active_in = 1'b0;
                     drain_in  = 1'b0;
                  end else begin
                     st_base = wrap_add(base_ff, start);
                     st_tail = fend - start;
                     go      = 1'b1;
                  end
               end
               if (go) begin
                  push     = 1'b1;
                  job_addr = st_base;
                  job_ctl  = '{op: OP_DRAIN, flag: (st_tail <= TW'(1))};
                  if (st_tail <= TW'(1)) begin
                     pos_in    = '0;
                     base_in   = '0;
                     tail_in   = '0;
                     active_in = 1'b0;
                     drain_in  = 1'b0;
                  end else begin
                     tail_in  = st_tail - TW'(1);
                     base_in  = wrap_add(st_base, TW'(1));
                     drain_in = 1'b1;
                  end
               end
            end
            CMD_LOAD: begin
               if (32'(req.coef_index) < FRAME_LENGTH) begin
                  push     = 1'b1;
                  job_ctl  = '{op: OP_LOAD, flag: 1'b0};
                  job_addr = PW'(req.coef_index);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         base_ff   <= '0;
         tail_ff   <= '0;
         active_ff <= 1'b0;
         drain_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         base_ff   <= base_in;
         tail_ff   <= tail_in;
         active_ff <= active_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

// ===== rtl/woas_queue.sv =====
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module woas_queue
   import woas_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = data_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/woas_back.sv =====
// Back end: ring accumulation, normalizing divide, output word and ring clearing.
`timescale 1ns / 1ps

module woas_back
   import woas_pkg::*;
#(
   parameter int FRAME_LENGTH = 512,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [NORM_W-1:0]               norm_floor,
   input  logic                            q_empty,
   output logic                            pop,
   input  job_ctl_type                     job_ctl,
   input  logic [$clog2(FRAME_LENGTH)-1:0] job_addr,
   input  logic [$clog2(FRAME_LENGTH)-1:0] job_widx,
   input  logic signed [SAMPLE_BITS-1:0]   job_sample,
   input  logic [COEF_W-1:0]               job_coef,
   woas_rsp_if.source                      rsp,
   output be_status_type                   status
);

   localparam int SB   = SAMPLE_BITS;
   localparam int PW   = $clog2(FRAME_LENGTH);
   localparam int DW   = NORM_W + $clog2(FRAME_LENGTH + 1);
   localparam int QW   = SB + 16;
   localparam int CNTW = $clog2(QW + 1);
   localparam int PRW  = SB + COEF_W + 1;
   localparam int CW   = (DW + SB > SUM_W) ? DW + SB : SUM_W;
   localparam logic [DW-1:0] FL_D   = DW'(FRAME_LENGTH);
   localparam logic [DW-1:0] UNIT_D = DW'(64'd1 << 30);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_MULT  = 8'b0000_0100,
      ST_ADD   = 8'b0000_1000,
      ST_PREP  = 8'b0001_0000,
      ST_CHECK = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } be_state_type;

   logic signed [SUM_W-1:0] sum_mem [FRAME_LENGTH];
   logic [NORM_W-1:0]       norm_mem [FRAME_LENGTH];
   logic [COEF_W-1:0]       win_mem [FRAME_LENGTH];

   be_state_type            state_ff, state_in;
   logic                    init_ff, init_in;
   logic [PW-1:0]           clr_ff, clr_in;
   job_ctl_type             ctl_ff;
   logic [PW-1:0]           addr_ff;
   logic signed [SB-1:0]    sample_ff;
   logic signed [SUM_W-1:0] sum_rd_ff;
   logic [NORM_W-1:0]       norm_rd_ff;
   logic [COEF_W-1:0]       win_rd_ff;
   logic signed [PRW-1:0]   prod_ff, prod_in;
   logic [2*COEF_W-1:0]     wsq_ff, wsq_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [NORM_W-1:0]       nrm_ff, nrm_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;
   logic [DW:0]             rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic                    ring_we;
   logic [PW-1:0]           ring_addr;
   logic signed [SUM_W-1:0] ring_sum;
   logic [NORM_W-1:0]       ring_norm;
   logic signed [SUM_W-1:0] sum_new;
   logic [NORM_W:0]         norm_sum;
   logic [NORM_W-1:0]       nrm_new;
   logic                    keep;
   logic [DW:0]             trial;
   logic                    ge;
   logic [QW:0]             q_round;
   logic [QW-1:0]           q, lim;
   logic                    sat;

   assign status.init_busy  = init_ff;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_sample     = rsp_sample_ff;
   assign rsp.last_of_stream = rsp_last_ff;
   assign rsp.saturated      = rsp_sat_ff;
   assign pop                = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      sum_new  = sum_rd_ff + SUM_W'(prod_ff);
      norm_sum = (NORM_W+1)'(norm_rd_ff) + (NORM_W+1)'(wsq_ff);
      nrm_new  = norm_sum[NORM_W] ? '1 : norm_sum[NORM_W-1:0];
      keep     = (ctl_ff.op == OP_ACCUM) && !ctl_ff.flag;
      trial    = {rem_ff[DW-1:0], quo_ff[QW-1]};
      ge       = trial >= {1'b0, d_ff};
      q_round  = (QW+1)'(quo_ff) + (QW+1)'(1);
      q        = q_round[QW:1];
      lim      = neg_ff ? QW'(64'd1 << (SB - 1)) : QW'((64'd1 << (SB - 1)) - 64'd1);
      sat      = ovf_ff || (q > lim);
      if (sat) q = lim;
   end

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      clr_in        = clr_ff;
      prod_in       = prod_ff;
      wsq_in        = wsq_ff;
      acc_in        = acc_ff;
      nrm_in        = nrm_ff;
      d_in          = d_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      ovf_in        = ovf_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_sat_in    = rsp_sat_ff;
      ring_we       = 1'b0;
      ring_addr     = addr_ff;
      ring_sum      = '0;
      ring_norm     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ring_we   = 1'b1;
            ring_addr = clr_ff;
            if (32'(clr_ff) == FRAME_LENGTH - 1) begin
               clr_in   = '0;
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + PW'(1);
            end
         end
         ST_IDLE: begin
            if (pop) begin
               unique case (job_ctl.op) inside
                  OP_LOAD:             state_in = ST_IDLE;
                  OP_CLEAR:            state_in = ST_CLEAR;
                  OP_ACCUM, OP_DRAIN:  state_in = ST_MULT;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_MULT: begin
            if (ctl_ff.op == OP_ACCUM) begin
               prod_in = PRW'(sample_ff * $signed({1'b0, win_rd_ff}));
               wsq_in  = win_rd_ff * win_rd_ff;
            end else begin
               prod_in = '0;
               wsq_in  = '0;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in    = sum_new;
            nrm_in    = nrm_new;
            ring_we   = 1'b1;
            ring_sum  = keep ? sum_new : '0;
            ring_norm = keep ? nrm_new : '0;
            state_in  = keep ? ST_IDLE : ST_PREP;
         end
         ST_PREP: begin
            neg_in   = acc_ff[SUM_W-1];
            mag_in   = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
            d_in     = ((nrm_ff > norm_floor) ? DW'(nrm_ff) : UNIT_D) * FL_D;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ovf_in   = CW'(mag_ff) >= (CW'(d_ff) << SB);
            rem_in   = (DW+1)'(mag_ff >> SB);
            quo_in   = {mag_ff[SB-1:0], 16'd0};
            cnt_in   = CNTW'(QW);
            state_in = ovf_in ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? (trial - {1'b0, d_ff}) : trial;
            quo_in = {quo_ff[QW-2:0], ge};
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = neg_ff ? SB'(-q) : SB'(q);
               rsp_last_in   = (ctl_ff.op == OP_DRAIN) && ctl_ff.flag;
               rsp_sat_in    = sat;
               state_in      = rsp_last_in ? ST_CLEAR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         sum_mem[ring_addr]  <= ring_sum;
         norm_mem[ring_addr] <= ring_norm;
      end
      if (pop) begin
         sum_rd_ff  <= sum_mem[job_addr];
         norm_rd_ff <= norm_mem[job_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && job_ctl.op == OP_LOAD) win_mem[job_addr] <= job_coef;
      if (pop) win_rd_ff <= win_mem[job_widx];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ctl_ff    <= job_ctl;
         addr_ff   <= job_addr;
         sample_ff <= job_sample;
      end
      prod_ff       <= prod_in;
      wsq_ff        <= wsq_in;
      acc_ff        <= acc_in;
      nrm_ff        <= nrm_in;
      d_ff          <= d_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      ovf_ff        <= ovf_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {1'b0, d_ff}))
      else $error("divider remainder not below divisor");
   a_div_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != '0))
      else $error("divider running with zero count");
   a_word_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response word raised outside the done state");
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("job taken during the power-up ring clear");
`endif

endmodule

// ===== rtl/windowed_overlap_add_synthesis_unit.sv =====
// Top level of the windowed overlap-add synthesis unit with its register port.
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          command, frame_sample, coef_index, coef_value
//   rsp_chan  out        valid/ready          out_sample, last_of_stream, saturated
//   csr_*     in/out     APB psel/penable     hop_length at 0x0, norm_floor at 0x8
//
// A window load is written in the back end's idle state; a sample word that emits nothing
// passes the multiply and add states. An emitting sample or flush word adds the prepare,
// check, divide (radix-2 restoring, one quotient bit per cycle, skipped on overflow) and
// done states. After reset, a stream's last word or an empty flush the back end clears
// both rings, one slot a cycle; req_chan stays low-ready during the reset clear.
// A two-entry job queue lets the front end keep accepting words while the divider runs,
// and the response register lets the back end finish the next word while one waits.
`timescale 1ns / 1ps

module windowed_overlap_add_synthesis_unit
   import woas_pkg::*;
#(
   parameter int FRAME_LENGTH = 512,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   woas_req_if.sink           req_chan,
   woas_rsp_if.source         rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_A_W-1:0] csr_paddr,
   input  logic [CSR_W-1:0]   csr_pwdata,
   output logic [CSR_W-1:0]   csr_prdata,
   output logic               csr_pready
);

   localparam int PW = $clog2(FRAME_LENGTH);
   localparam int JW = $bits(job_ctl_type) + 2 * PW + SAMPLE_BITS + COEF_W;

   // Configuration registers. The word address is decoded on bit 3 only.
   logic [HOP_W-1:0]  hop_ff, hop_in;
   logic [NORM_W-1:0] floor_ff, floor_in;
   logic              csr_write;

   // Job path between the front end, the queue and the back end.
   logic                    push, pop, q_empty, q_full;
   job_ctl_type             f_ctl, b_ctl;
   logic [PW-1:0]           f_addr, f_widx, b_addr, b_widx;
   logic signed [SAMPLE_BITS-1:0] f_sample, b_sample;
   logic [COEF_W-1:0]       f_coef, b_coef;
   logic [JW-1:0]           q_in, q_out;
   be_status_type           status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_FLOOR) ? CSR_W'(floor_ff) : CSR_W'(hop_ff);

   always_comb begin
      hop_in   = hop_ff;
      floor_in = floor_ff;
      if (csr_write) begin
         if (csr_paddr[3] == REG_HOP) hop_in = csr_pwdata[HOP_W-1:0];
         else floor_in = csr_pwdata[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff   <= HOP_RESET;
         floor_ff <= FLOOR_RESET;
      end else begin
         hop_ff   <= hop_in;
         floor_ff <= floor_in;
      end
   end

   woas_front #(
      .FRAME_LENGTH (FRAME_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .hop_length (hop_ff),
      .status     (status),
      .q_full     (q_full),
      .push       (push),
      .job_ctl    (f_ctl),
      .job_addr   (f_addr),
      .job_widx   (f_widx),
      .job_sample (f_sample),
      .job_coef   (f_coef)
   );

   assign q_in = {f_ctl, f_addr, f_widx, f_sample, f_coef};
   assign {b_ctl, b_addr, b_widx, b_sample, b_coef} = q_out;

   woas_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .full      (q_full)
   );

   woas_back #(
      .FRAME_LENGTH (FRAME_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .norm_floor (floor_ff),
      .q_empty    (q_empty),
      .pop        (pop),
      .job_ctl    (b_ctl),
      .job_addr   (b_addr),
      .job_widx   (b_widx),
      .job_sample (b_sample),
      .job_coef   (b_coef),
      .rsp        (rsp_chan),
      .status     (status)
   );

endmodule
